// File: rtl/core/stl_pkg.sv
// ============================================================================
// stl_pkg
// Shared types and constants of the storage throughput load detector.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package stl_pkg;

    // field widths
    localparam int DISK_W  = 3;
    localparam int TOTAL_W = 64;
    localparam int LIMIT_W = 32;
    localparam int LEVEL_W = 8;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_READ_LIMIT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_LEVEL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_LEVEL   = 3'd3;

    localparam logic [LIMIT_W-1:0] READ_LIMIT_RST  = 32'd10240;
    localparam logic [LIMIT_W-1:0] WRITE_LIMIT_RST = 32'd8192;
    localparam logic [LEVEL_W-1:0] HIGH_LEVEL_RST  = 8'd125;
    localparam logic [LEVEL_W-1:0] LOW_LEVEL_RST   = 8'd25;

    // stream packing
    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = 8;

    // result queue
    localparam int Q_DEPTH = 3;
    localparam int Q_CNT_W = 2;

    typedef struct packed {
        logic [DISK_W-1:0]  disk_index;
        logic               sample_valid;
        logic [TOTAL_W-1:0] read_total;
        logic [TOTAL_W-1:0] write_total;
        logic               period_end;
    } t_sample;

    typedef struct packed {
        logic [LEVEL_W-1:0] requested_level;
        logic               load_high;
    } t_result;

    typedef struct packed {
        logic [LIMIT_W-1:0] read_limit;
        logic [LIMIT_W-1:0] write_limit;
        logic [LEVEL_W-1:0] high_level;
        logic [LEVEL_W-1:0] low_level;
    } t_cfg;

endpackage

`default_nettype wire

// File: rtl/core/stl_ram.sv
// ============================================================================
// stl_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module stl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: rtl/core/stl_tracker.sv
// ============================================================================
// stl_tracker
// Per-disk history RAM with read-modify-write, growth test and busy mode.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module stl_tracker #(
    parameter int DISKS = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire stl_pkg::t_sample i_sample,
    input  wire stl_pkg::t_cfg    i_cfg,
    output logic                  o_pending,   // item in flight may push a result
    output logic                  o_push,
    output stl_pkg::t_result      o_result
);

    localparam int AW  = (DISKS > 1) ? $clog2(DISKS) : 1;
    localparam int MW  = 2 * stl_pkg::TOTAL_W;
    localparam logic [6:0] DISKS_N = 7'(DISKS);

    logic                  r_s1_vld;
    stl_pkg::t_sample      r_s1;
    logic [DISKS-1:0]      r_vld;
    logic                  r_fwd_vld;
    logic [AW-1:0]         r_fwd_addr;
    logic [MW-1:0]         r_fwd_data;
    logic                  r_period_busy;
    logic                  r_busy_mode;

    logic [AW-1:0]               w_rd_addr;
    logic [AW-1:0]               w_s1_addr;
    logic [MW-1:0]               w_ram_rdata;
    logic [MW-1:0]               w_prev;
    logic [stl_pkg::TOTAL_W-1:0] w_prev_rd;
    logic [stl_pkg::TOTAL_W-1:0] w_prev_wr;
    logic [stl_pkg::TOTAL_W-1:0] w_diff_rd;
    logic [stl_pkg::TOTAL_W-1:0] w_diff_wr;
    logic                        w_hit;
    logic                        w_busy_rd;
    logic                        w_busy_wr;
    logic                        w_busy_now;
    logic                        n_period_busy;

    assign w_rd_addr = AW'(i_sample.disk_index);
    assign w_s1_addr = AW'(r_s1.disk_index);
    assign w_hit     = r_s1_vld && r_s1.sample_valid
                     && ({4'b0, r_s1.disk_index} < DISKS_N);

    stl_ram #(
        .WIDTH (MW),
        .DEPTH (DISKS)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (w_hit),
        .i_waddr (w_s1_addr),
        .i_wdata ({r_s1.write_total, r_s1.read_total}),
        .i_raddr (w_rd_addr),
        .o_rdata (w_ram_rdata)
    );

    // forward the write of the previous cycle; untouched entries read as zero
    always_comb begin
        if (r_fwd_vld && (r_fwd_addr == w_s1_addr)) begin
            w_prev = r_fwd_data;
        end else if (r_vld[w_s1_addr]) begin
            w_prev = w_ram_rdata;
        end else begin
            w_prev = '0;
        end
    end

    assign w_prev_rd = w_prev[stl_pkg::TOTAL_W-1:0];
    assign w_prev_wr = w_prev[MW-1:stl_pkg::TOTAL_W];
    assign w_diff_rd = r_s1.read_total - w_prev_rd;
    assign w_diff_wr = r_s1.write_total - w_prev_wr;

    assign w_busy_rd = (w_prev_rd != '0) && (r_s1.read_total > w_prev_rd)
                     && (w_diff_rd > {32'b0, i_cfg.read_limit});
    assign w_busy_wr = (w_prev_wr != '0) && (r_s1.write_total > w_prev_wr)
                     && (w_diff_wr > {32'b0, i_cfg.write_limit});

    assign n_period_busy = r_period_busy || (w_hit && (w_busy_rd || w_busy_wr));
    assign w_busy_now    = n_period_busy;

    assign o_pending = r_s1_vld && r_s1.period_end;
    assign o_push    = o_pending && (w_busy_now != r_busy_mode);
    assign o_result.requested_level = w_busy_now ? i_cfg.high_level : i_cfg.low_level;
    assign o_result.load_high       = w_busy_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld      <= 1'b0;
            r_vld         <= '0;
            r_fwd_vld     <= 1'b0;
            r_period_busy <= 1'b0;
            r_busy_mode   <= 1'b0;
        end else begin
            r_s1_vld  <= i_accept;
            r_fwd_vld <= w_hit;
            if (w_hit) begin
                r_vld[w_s1_addr] <= 1'b1;
            end
            if (o_pending) begin
                r_busy_mode   <= w_busy_now;
                r_period_busy <= 1'b0;
            end else begin
                r_period_busy <= n_period_busy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1 <= i_sample;
        end
        r_fwd_addr <= w_s1_addr;
        r_fwd_data <= {r_s1.write_total, r_s1.read_total};
    end

`ifndef SYNTH
    a_push_on_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (r_s1_vld && r_s1.period_end))
        else $error("result pushed outside a period close");

    a_mode_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_busy_mode == $past(o_result.load_high)))
        else $error("busy mode does not match the emitted level");

    a_busy_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_s1.period_end) |=> !r_period_busy)
        else $error("period busy flag not cleared at period close");
`endif

endmodule

`default_nettype wire

// File: rtl/core/stl_out_queue.sv
// ============================================================================
// stl_out_queue
// Small result queue feeding the master stream; head entry drives the port.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module stl_out_queue (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    input  wire stl_pkg::t_result              i_data,
    input  wire logic                          i_pop,
    output logic                               o_valid,
    output stl_pkg::t_result                   o_data,
    output logic [stl_pkg::Q_CNT_W-1:0]        o_cnt
);

    stl_pkg::t_result                r_q [stl_pkg::Q_DEPTH];
    stl_pkg::t_result                n_q [stl_pkg::Q_DEPTH];
    logic [stl_pkg::Q_CNT_W-1:0]     r_cnt;
    logic [stl_pkg::Q_CNT_W-1:0]     n_cnt;

    always_comb begin
        n_q   = r_q;
        n_cnt = r_cnt;
        if (i_pop) begin
            for (int i = 0; i < stl_pkg::Q_DEPTH - 1; i++) begin
                n_q[i] = r_q[i+1];
            end
            n_cnt = r_cnt - (stl_pkg::Q_CNT_W)'(1);
        end
        if (i_push) begin
            n_q[n_cnt] = i_data;
            n_cnt      = n_cnt + (stl_pkg::Q_CNT_W)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_q[0];
    assign o_cnt   = r_cnt;

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> ((r_cnt < (stl_pkg::Q_CNT_W)'(stl_pkg::Q_DEPTH)) || i_pop))
        else $error("result queue overflow");

    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_cnt == '0) && i_push) |=> o_valid)
        else $error("pushed result not presented");

    a_drain_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_cnt == 2'd1) && i_pop && !i_push) |=> !o_valid)
        else $error("queue still valid after last entry left");
`endif

endmodule

`default_nettype wire

// File: rtl/core/storage_throughput_load_detector.sv
// ============================================================================
// storage_throughput_load_detector
// Per-disk sector throughput monitor that requests a performance level.
// ============================================================================
// One sample is taken every clock cycle while the slave side does not stall.
// Each transfer reads the disk's previous totals from the history RAM,
// compares and writes back on the next cycle (back-to-back hits on one disk
// are forwarded), and a closing sample may push a result into the queue that
// feeds the master port. The slave side stalls only when the three-entry
// result queue could not take a possible result. The history starts out all
// zero through per-disk valid bits; no clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module storage_throughput_load_detector #(
    parameter int DISKS = 8
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // slave stream
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [2:0] disk_index, [66:3] read_total, [130:67] write_total, rest zero
    input  wire logic [stl_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    input  wire logic                             s_axis_tlast,   // period_end
    input  wire logic                             s_axis_tuser,   // sample_valid
    // master stream
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic      [stl_pkg::M_TDATA_W-1:0]    m_axis_tdata,   // [7:0] requested_level
    output logic                                  m_axis_tuser,   // load_high
    // configuration write
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [stl_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [stl_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    stl_pkg::t_cfg                  r_cfg;
    stl_pkg::t_sample               w_sample;
    stl_pkg::t_result               w_push_data;
    stl_pkg::t_result               w_head;
    logic                           w_accept;
    logic                           w_pending;
    logic                           w_push;
    logic                           w_pop;
    logic [stl_pkg::Q_CNT_W-1:0]    w_cnt;
    logic [stl_pkg::Q_CNT_W:0]      w_claim;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.read_limit  <= stl_pkg::READ_LIMIT_RST;
            r_cfg.write_limit <= stl_pkg::WRITE_LIMIT_RST;
            r_cfg.high_level  <= stl_pkg::HIGH_LEVEL_RST;
            r_cfg.low_level   <= stl_pkg::LOW_LEVEL_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                stl_pkg::REG_READ_LIMIT:  r_cfg.read_limit  <= i_cfg_data;
                stl_pkg::REG_WRITE_LIMIT: r_cfg.write_limit <= i_cfg_data;
                stl_pkg::REG_HIGH_LEVEL:  r_cfg.high_level  <= i_cfg_data[7:0];
                stl_pkg::REG_LOW_LEVEL:   r_cfg.low_level   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign w_sample.disk_index   = s_axis_tdata[2:0];
    assign w_sample.read_total   = s_axis_tdata[66:3];
    assign w_sample.write_total  = s_axis_tdata[130:67];
    assign w_sample.sample_valid = s_axis_tuser;
    assign w_sample.period_end   = s_axis_tlast;

    // queued results plus one that the in-flight item may still push
    assign w_claim       = {1'b0, w_cnt} + {{stl_pkg::Q_CNT_W{1'b0}}, w_pending};
    assign s_axis_tready = (w_claim < (stl_pkg::Q_CNT_W + 1)'(stl_pkg::Q_DEPTH));
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_pop         = m_axis_tvalid && m_axis_tready;

    stl_tracker #(
        .DISKS (DISKS)
    ) u_tracker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_sample  (w_sample),
        .i_cfg     (r_cfg),
        .o_pending (w_pending),
        .o_push    (w_push),
        .o_result  (w_push_data)
    );

    stl_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .o_data  (w_head),
        .o_cnt   (w_cnt)
    );

    assign m_axis_tdata = w_head.requested_level;
    assign m_axis_tuser = w_head.load_high;

endmodule

`default_nettype wire

// File: tb/sv/storage_throughput_load_detector_tb.sv
// ============================================================================
// storage_throughput_load_detector_tb
// Drives per-disk sector totals in sampling periods and checks every level
// request against a cycle-free prediction of the busy-mode tracker.
// ============================================================================
`timescale 1ns / 1ps

module storage_throughput_load_detector_tb;

    import stl_pkg::*;

    localparam int DISKS         = 8;
    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 8;
    localparam int RUN_LIMIT     = 500000;
    localparam int PHASE_SAMPLES = 250;
    localparam int REG_SPARE_MIN = int'(REG_LOW_LEVEL) + 1;
    localparam int REG_SPARE_MAX = (1 << CFG_IDX_W) - 1;

    typedef enum logic [1:0] {SINK_OPEN, SINK_LIGHT, SINK_HEAVY, SINK_COMB} sink_mode_e;

    // ------------------------------------------------------------------------
    // Busy-mode tracker: keeps per-disk history and the expected level requests
    // ------------------------------------------------------------------------
    class load_mode_tracker;
        logic [TOTAL_W-1:0] prev_read  [1 << DISK_W];
        logic [TOTAL_W-1:0] prev_write [1 << DISK_W];
        bit                 period_busy;
        bit                 busy_mode;
        logic [LIMIT_W-1:0] read_limit;
        logic [LIMIT_W-1:0] write_limit;
        logic [LEVEL_W-1:0] high_level;
        logic [LEVEL_W-1:0] low_level;
        t_result            pending_levels[$];
        int                 mismatches;

        function new();
            foreach (prev_read[i]) begin
                prev_read[i]  = '0;
                prev_write[i] = '0;
            end
            period_busy = 1'b0;
            busy_mode   = 1'b0;
            read_limit  = READ_LIMIT_RST;
            write_limit = WRITE_LIMIT_RST;
            high_level  = HIGH_LEVEL_RST;
            low_level   = LOW_LEVEL_RST;
            mismatches  = 0;
        endfunction

        // zero history means no earlier sample
        static function bit outgrew(logic [TOTAL_W-1:0] prior, logic [TOTAL_W-1:0] latest,
                                    logic [LIMIT_W-1:0] lim);
            return prior != '0 && latest > prior && (latest - prior) > {32'b0, lim};
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_READ_LIMIT:  read_limit  = data;
                REG_WRITE_LIMIT: write_limit = data;
                REG_HIGH_LEVEL:  high_level  = data[LEVEL_W-1:0];
                REG_LOW_LEVEL:   low_level   = data[LEVEL_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_sample(t_sample s);
            t_result lvl;
            bit      now_busy;
            if (s.sample_valid && int'(s.disk_index) < DISKS) begin
                if (outgrew(prev_read[s.disk_index], s.read_total, read_limit))
                    period_busy = 1'b1;
                prev_read[s.disk_index] = s.read_total;
                if (outgrew(prev_write[s.disk_index], s.write_total, write_limit))
                    period_busy = 1'b1;
                prev_write[s.disk_index] = s.write_total;
            end
            if (!s.period_end)
                return;
            now_busy    = period_busy;
            period_busy = 1'b0;
            if (now_busy == busy_mode)
                return;
            busy_mode           = now_busy;
            lvl.requested_level = now_busy ? high_level : low_level;
            lvl.load_high       = now_busy;
            pending_levels.push_back(lvl);
        endfunction

        function void check_level(logic [LEVEL_W-1:0] level, logic high);
            t_result want;
            if (pending_levels.size() == 0) begin
                $error("unexpected result: requested_level %0d load_high %0b", level, high);
                mismatches++;
                return;
            end
            want = pending_levels.pop_front();
            if (level !== want.requested_level) begin
                $error("requested_level: expected %0d, got %0d", want.requested_level, level);
                mismatches++;
            end
            if (high !== want.load_high) begin
                $error("load_high: expected %0b, got %0b", want.load_high, high);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tlast  = 1'b0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    storage_throughput_load_detector #(
        .DISKS(DISKS)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    load_mode_tracker   tracker;
    sink_mode_e         sink_mode = SINK_OPEN;
    int                 cycle_count = 0;
    int                 gap_max = 0;
    int                 burst_left = 0;
    int                 samples_sent = 0;
    logic [TOTAL_W-1:0] run_rd [DISKS];
    logic [TOTAL_W-1:0] run_wr [DISKS];

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= RUN_LIMIT);
        $display("storage_throughput_load_detector_tb failed");
        $finish;
    end

    // result side: check each transfer, then pick next cycle's ready
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_level(m_axis_tdata, m_axis_tuser);
        case (sink_mode)
            SINK_OPEN:  m_axis_tready <= 1'b1;
            SINK_LIGHT: m_axis_tready <= ($urandom_range(9) >= 3);
            SINK_HEAVY: m_axis_tready <= ($urandom_range(9) >= 8);
            default:    m_axis_tready <= ((cycle_count % 8) >= 3);
        endcase
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_sample mk_sample(logic [DISK_W-1:0] d, logic v,
                                          logic [TOTAL_W-1:0] rd, logic [TOTAL_W-1:0] wr,
                                          logic last);
        t_sample s;
        s.disk_index   = d;
        s.sample_valid = v;
        s.read_total   = rd;
        s.write_total  = wr;
        s.period_end   = last;
        return s;
    endfunction

    // totals and index of an empty item are don't-care, so fill them with noise
    function automatic t_sample empty_item(logic last);
        return mk_sample(DISK_W'($urandom_range((1 << DISK_W) - 1)), 1'b0,
                         {$urandom, $urandom}, {$urandom, $urandom}, last);
    endfunction

    function automatic logic [TOTAL_W-1:0] quiet_step(logic [LIMIT_W-1:0] lim);
        case ($urandom_range(3))
            0:       return '0;
            1:       return {32'b0, lim};
            default: return {32'b0, $urandom} % ({32'b0, lim} + 64'd1);
        endcase
    endfunction

    function automatic logic [TOTAL_W-1:0] busy_step(logic [LIMIT_W-1:0] lim);
        case ($urandom_range(2))
            0:       return {32'b0, lim} + 64'd1;
            1:       return {32'b0, lim} + 64'd1 + 64'($urandom_range(15));
            default: return {32'b0, lim} + 64'd1 + {32'b0, $urandom};
        endcase
    endfunction

    task automatic send_sample(input t_sample s);
        if (burst_left == 0) begin
            if (gap_max != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(gap_max, 1)) @(posedge i_clk);
            end
            burst_left = $urandom_range(24, 1);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W - 2 * TOTAL_W - DISK_W){1'b0}},
                          s.write_total, s.read_total, s.disk_index};
        s_axis_tuser  <= s.sample_valid;
        s_axis_tlast  <= s.period_end;
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.note_sample(s);
        if (s.sample_valid)
            samples_sent++;
    endtask

    // hold off the sender until every level request has been seen
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending_levels.size() != 0);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.write_reg(idx, data);
    endtask

    task automatic reconfigure(input logic [LIMIT_W-1:0] rd_lim, input logic [LIMIT_W-1:0] wr_lim,
                               input logic [LEVEL_W-1:0] hi_lvl, input logic [LEVEL_W-1:0] lo_lvl);
        logic [CFG_DATA_W-1:0] junk;
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_write(REG_READ_LIMIT, rd_lim);
        cfg_write(REG_WRITE_LIMIT, wr_lim);
        junk = $urandom;
        cfg_write(REG_HIGH_LEVEL, {junk[CFG_DATA_W-1:LEVEL_W], hi_lvl});   // upper bits dropped
        junk = $urandom;
        cfg_write(REG_LOW_LEVEL, {junk[CFG_DATA_W-1:LEVEL_W], lo_lvl});
        cfg_write(CFG_IDX_W'($urandom_range(REG_SPARE_MAX, REG_SPARE_MIN)), $urandom);
        i_cfg_valid <= 1'b0;
    endtask

    // knock a disk's running totals around: zero, random, or near the top
    task automatic disturb(input logic [DISK_W-1:0] d);
        case ($urandom_range(3))
            0:       run_rd[d] = '0;
            1:       run_wr[d] = {$urandom, $urandom};
            2:       run_rd[d] = '1 - 64'($urandom_range(3));
            default: begin
                run_rd[d] = {$urandom, $urandom};
                run_wr[d] = '0;
            end
        endcase
    endtask

    // one sample per disk for a run of disks; the hot disk crosses a limit when busy is wanted
    task automatic run_period(input bit want_busy);
        int                n;
        int                first;
        int                hot;
        int                k;
        bit                hot_read;
        bit                hot_write;
        bit                close_empty;
        logic [DISK_W-1:0] d;
        n           = $urandom_range(DISKS, 1);
        first       = $urandom_range(DISKS - 1);
        hot         = $urandom_range(n - 1);
        hot_read    = ($urandom_range(1) == 1);
        hot_write   = !hot_read || ($urandom_range(3) == 0);
        close_empty = ($urandom_range(9) == 0);
        for (k = 0; k < n; k++) begin
            if ($urandom_range(15) == 0)
                send_sample(empty_item(1'b0));
            d = DISK_W'((first + k) % DISKS);
            run_rd[d] = run_rd[d] + ((want_busy && k == hot && hot_read) ?
                        busy_step(tracker.read_limit) : quiet_step(tracker.read_limit));
            run_wr[d] = run_wr[d] + ((want_busy && k == hot && hot_write) ?
                        busy_step(tracker.write_limit) : quiet_step(tracker.write_limit));
            if ($urandom_range(24) == 0)
                disturb(d);
            send_sample(mk_sample(d, 1'b1, run_rd[d], run_wr[d], k == n - 1 && !close_empty));
        end
        if (close_empty)
            send_sample(empty_item(1'b1));
    endtask

    task automatic noise_period();
        int      n;
        int      k;
        t_sample s;
        n = $urandom_range(6, 1);
        for (k = 0; k < n; k++) begin
            s.disk_index   = DISK_W'($urandom_range((1 << DISK_W) - 1));
            s.sample_valid = ($urandom_range(3) != 0);
            s.read_total   = ($urandom_range(1) == 1) ? {$urandom, $urandom} :
                             run_rd[s.disk_index] + busy_step(tracker.read_limit);
            s.write_total  = ($urandom_range(1) == 1) ? {$urandom, $urandom} :
                             run_wr[s.disk_index] + busy_step(tracker.write_limit);
            s.period_end   = (k == n - 1) || ($urandom_range(7) == 0);
            if (s.sample_valid) begin
                run_rd[s.disk_index] = s.read_total;
                run_wr[s.disk_index] = s.write_total;
            end
            send_sample(s);
        end
    endtask

    task automatic run_phase(input sink_mode_e mode, input int gaps, input int target);
        int start;
        int pick;
        sink_mode = mode;
        gap_max   = gaps;
        start     = samples_sent;
        while (samples_sent - start < target) begin
            pick = $urandom_range(99);
            if (pick < 80)
                run_period(tracker.busy_mode ^ ($urandom_range(2) != 0));
            else if (pick < 95)
                noise_period();
            else
                drain();
        end
    endtask

    // short directed walk with the reset limits
    task automatic directed_walk();
        send_sample(mk_sample(3'd0, 1'b1, 64'd100, 64'd100, 1'b0));    // first sample
        send_sample(mk_sample(3'd7, 1'b1, '1, '1, 1'b1));
        send_sample(mk_sample(3'd0, 1'b1, 64'd10340, 64'd8292, 1'b1)); // exactly at limits
        send_sample(mk_sample(3'd0, 1'b1, 64'd20581, 64'd8292, 1'b1)); // read above: high
        send_sample(mk_sample(3'd0, 1'b1, 64'd20581, 64'd16485, 1'b1)); // still busy
        send_sample(mk_sample(3'd5, 1'b0, '1, '1, 1'b1));              // empty close: low
        send_sample(mk_sample(3'd0, 1'b1, 64'd5, 64'd5, 1'b0));        // totals went down
        send_sample(mk_sample(3'd7, 1'b1, 64'd1, 64'd1, 1'b1));
        send_sample(mk_sample(3'd0, 1'b1, 64'd0, 64'd0, 1'b0));        // history back to zero
        send_sample(mk_sample(3'd0, 1'b1, '1, '1, 1'b1));              // no compare
        send_sample(mk_sample(3'd3, 1'b1, 64'd1, 64'd1, 1'b0));
        send_sample(mk_sample(3'd3, 1'b1, 64'd1, 64'd8194, 1'b0));     // write only, mid period
        send_sample(mk_sample(3'd4, 1'b1, 64'd9, 64'd9, 1'b1));        // high
        send_sample(mk_sample(3'd2, 1'b0, 64'd0, 64'd0, 1'b1));        // low
        send_sample(mk_sample(3'd1, 1'b1, 64'h8000_0000_0000_0000,
                              64'h5555_5555_5555_5555, 1'b0));
        send_sample(mk_sample(3'd1, 1'b1, 64'h8000_0001_0000_0000,
                              64'h5555_5555_5555_5555, 1'b1));        // high
        send_sample(mk_sample(3'd6, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA,
                              64'h5555_5555_5555_5555, 1'b1));        // low
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        tracker = new();
        foreach (run_rd[i]) begin
            run_rd[i] = '0;
            run_wr[i] = '0;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed_walk();
        run_phase(SINK_OPEN, 0, PHASE_SAMPLES);

        reconfigure('0, '0, 8'd255, 8'd0);
        run_phase(SINK_LIGHT, 3, PHASE_SAMPLES);

        reconfigure('1, '1, 8'd0, 8'd255);
        run_phase(SINK_HEAVY, 6, PHASE_SAMPLES);

        reconfigure(LIMIT_W'($urandom_range(20000)), LIMIT_W'($urandom_range(20000)),
                    LEVEL_W'($urandom), LEVEL_W'($urandom));
        run_phase(SINK_COMB, 2, PHASE_SAMPLES);

        reconfigure(32'd1, 32'h8000_0000, LEVEL_W'($urandom), LEVEL_W'($urandom));
        run_phase(SINK_LIGHT, 8, PHASE_SAMPLES);

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0)
            $display("storage_throughput_load_detector_tb passed");
        else
            $display("storage_throughput_load_detector_tb failed");
        $finish;
    end

endmodule
